[rtl/ioct_pkg.sv]
// ----------------------------------------------------------------------------
// ioct_pkg: shared types and constants for the completion tracker
// Opcodes, request kinds, status codes, queue entry type and the mapping
// from request outcome to completion status.
// ----------------------------------------------------------------------------
package ioct_pkg;

  // default sizes
  localparam int SLOTS_DEF      = 256;
  localparam int COUNT_BITS_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;

  // event opcodes
  typedef enum logic [1:0] {
    OP_ADD_FLASH  = 2'd0,
    OP_ADD_DMA    = 2'd1,
    OP_FLASH_DONE = 2'd2,
    OP_DMA_DONE   = 2'd3
  } op_e;

  // request kinds
  localparam logic [2:0] KIND_WRITE     = 3'd0;
  localparam logic [2:0] KIND_READ      = 3'd1;
  localparam logic [2:0] KIND_READ_XFER = 3'd2;
  localparam logic [2:0] KIND_ERASE     = 3'd3;
  localparam logic [2:0] KIND_RX_DMA    = 3'd4;
  localparam logic [2:0] KIND_TX_DMA    = 3'd5;

  // request status codes
  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_WARN = 2'd1;

  // completion status
  localparam logic [2:0] SCT_GENERIC         = 3'd0;
  localparam logic [2:0] SCT_MEDIA           = 3'd2;
  localparam logic [7:0] SC_OK               = 8'h00;
  localparam logic [7:0] SC_WR_FAULT         = 8'h80;
  localparam logic [7:0] SC_UNRECOVERED_READ = 8'h81;
  localparam logic [7:0] SC_ACCESS_DENY      = 8'h86;

  // classified event held in the queue
  typedef struct packed {
    op_e        op;
    logic [7:0] slot;
    logic [2:0] kind;
    logic       bad;
  } cmd_t;

  typedef struct packed {
    logic [2:0] sct;
    logic [7:0] sc;
  } status_t;

  // back end status seen by the top level
  typedef struct packed {
    logic clearing;
    logic load;
  } back_stat_t;

  // success of a flash child for its kind and status
  function automatic logic flash_ok(logic [2:0] kind, logic [1:0] status);
    logic ok;
    case (kind)
      KIND_WRITE, KIND_ERASE: ok = (status == STAT_DONE);
      KIND_READ_XFER:         ok = (status == STAT_DONE) || (status == STAT_WARN);
      default:                ok = 1'b0;
    endcase
    return ok;
  endfunction

  // completion status from the fail flag and the request kind
  function automatic status_t cpl_status(logic is_flash, logic [2:0] kind, logic failed);
    status_t st;
    st.sct = SCT_GENERIC;
    st.sc  = SC_OK;
    if (failed) begin
      if (is_flash) begin
        case (kind)
          KIND_WRITE: begin
            st.sct = SCT_MEDIA;
            st.sc  = SC_WR_FAULT;
          end
          KIND_READ, KIND_READ_XFER: begin
            st.sct = SCT_MEDIA;
            st.sc  = SC_UNRECOVERED_READ;
          end
          KIND_ERASE: begin
            st.sct = SCT_MEDIA;
            st.sc  = SC_ACCESS_DENY;
          end
          default: ;
        endcase
      end else begin
        case (kind)
          KIND_RX_DMA: begin
            st.sct = SCT_MEDIA;
            st.sc  = SC_WR_FAULT;
          end
          KIND_TX_DMA: begin
            st.sct = SCT_MEDIA;
            st.sc  = SC_UNRECOVERED_READ;
          end
          default: ;
        endcase
      end
    end
    return st;
  endfunction

endpackage

[rtl/ioct_evt_if.sv]
// ----------------------------------------------------------------------------
// ioct_evt_if: event channel
// Valid/ready channel carrying one add or completion event per beat.
// ----------------------------------------------------------------------------
interface ioct_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] slot;
  logic [2:0] request_kind;
  logic [1:0] request_status;

  modport source (output valid, opcode, slot, request_kind, request_status, input ready);
  modport sink   (input valid, opcode, slot, request_kind, request_status, output ready);
endinterface

[rtl/ioct_cpl_if.sv]
// ----------------------------------------------------------------------------
// ioct_cpl_if: completion channel
// Valid/ready channel carrying one command completion per beat.
// ----------------------------------------------------------------------------
interface ioct_cpl_if;
  logic       valid;
  logic       ready;
  logic [7:0] completion_slot;
  logic [2:0] status_code_type;
  logic [7:0] status_code;

  modport source (output valid, completion_slot, status_code_type, status_code, input ready);
  modport sink   (input valid, completion_slot, status_code_type, status_code, output ready);
endinterface

[rtl/ioct_front.sv]
// ----------------------------------------------------------------------------
// ioct_front: event intake
// Accepts event beats, drops slots out of range and classifies flash
// completions as good or bad before queueing them.
// ----------------------------------------------------------------------------
module ioct_front import ioct_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  ioct_evt_if.sink evt_i,
  input  logic     clearing_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output cmd_t     q_cmd_o
);

  logic accept;
  logic in_range;

  // hold off while the queue is full or the table is being cleared
  assign evt_i.ready = !q_full_i && !clearing_i;
  assign accept      = evt_i.valid && evt_i.ready;
  assign in_range    = (32'(evt_i.slot) < SLOTS);

  // classify the event
  always_comb begin
    q_cmd_o.op   = op_e'(evt_i.opcode);
    q_cmd_o.slot = evt_i.slot;
    q_cmd_o.kind = evt_i.request_kind;
    q_cmd_o.bad  = !flash_ok(evt_i.request_kind, evt_i.request_status);
  end

  assign q_push_o = accept && in_range;

endmodule

[rtl/ioct_queue.sv]
// ----------------------------------------------------------------------------
// ioct_queue: event queue
// Small fifo of classified events between the front and the back end.
// ----------------------------------------------------------------------------
module ioct_queue import ioct_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o,
  output logic empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          buf_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push;
  logic          do_pop;

  assign full_o    = (cnt_q == CW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = buf_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[rtl/ioct_back.sv]
// ----------------------------------------------------------------------------
// ioct_back: scoreboard update
// Read-modify-write of the per-slot counters and fail flag, completion
// forming and the output register; clears the table after reset.
// ----------------------------------------------------------------------------
module ioct_back import ioct_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  cmd_t       q_cmd_i,
  output logic       q_pop_o,
  output back_stat_t stat_o,
  ioct_cpl_if.source cpl_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CB = COUNT_BITS;
  localparam int EW = 2 * CB + 1;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] clr_q, clr_d;
  cmd_t          cmd_q, cmd_d;

  // slot table: {fail, dma count, flash count}
  logic [EW-1:0] mem [SLOTS];
  logic [EW-1:0] rd_q;
  logic          rd_en;
  logic [IW-1:0] rd_idx;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [EW-1:0] wr_data;

  logic [CB-1:0] f_cnt, d_cnt, nf_cnt, nd_cnt;
  logic          fail, nfail, st_fail;
  logic          emit, is_flash;
  status_t       st;
  logic          out_busy;
  logic          load;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_slot_q;
  status_t       out_st_q;

  assign f_cnt = rd_q[CB-1:0];
  assign d_cnt = rd_q[2*CB-1:CB];
  assign fail  = rd_q[2*CB];

  // entry update for the held event
  always_comb begin
    nf_cnt   = f_cnt;
    nd_cnt   = d_cnt;
    nfail    = fail;
    emit     = 1'b0;
    is_flash = 1'b0;
    case (cmd_q.op)
      OP_ADD_FLASH: begin
        if (!(&f_cnt)) nf_cnt = f_cnt + CB'(1);
      end
      OP_ADD_DMA: begin
        if (!(&d_cnt)) nd_cnt = d_cnt + CB'(1);
      end
      OP_FLASH_DONE: begin
        nfail = fail | cmd_q.bad;
        if (f_cnt != '0) begin
          nf_cnt   = f_cnt - CB'(1);
          emit     = (nf_cnt == '0);
          is_flash = 1'b1;
        end
      end
      OP_DMA_DONE: begin
        if (d_cnt != '0) begin
          nd_cnt = d_cnt - CB'(1);
          emit   = (nd_cnt == '0);
        end
      end
      default: ;
    endcase
    st_fail = nfail;
    st      = cpl_status(is_flash, cmd_q.kind, st_fail);
    if (emit) nfail = 1'b0;
  end

  assign out_busy = out_valid_q && !cpl_o.ready;

  // sequencer: clearing pass, fetch, update
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cmd_d   = cmd_q;
    rd_en   = 1'b0;
    rd_idx  = IW'(q_cmd_i.slot);
    wr_en   = 1'b0;
    wr_idx  = IW'(cmd_q.slot);
    wr_data = {nfail, nd_cnt, nf_cnt};
    q_pop_o = 1'b0;
    load    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_idx  = clr_q;
        wr_data = '0;
        if (clr_q == IW'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + IW'(1);
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          rd_en   = 1'b1;
          cmd_d   = q_cmd_i;
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!out_busy) begin
          wr_en   = 1'b1;
          load    = emit;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  // table read and write ports
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // output register
  assign out_valid_d = load || (out_valid_q && !cpl_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_slot_q <= cmd_q.slot;
      out_st_q   <= st;
    end
  end

  assign cpl_o.valid            = out_valid_q;
  assign cpl_o.completion_slot  = out_slot_q;
  assign cpl_o.status_code_type = out_st_q.sct;
  assign cpl_o.status_code      = out_st_q.sc;

  assign stat_o.clearing = (state_q == ST_CLEAR);
  assign stat_o.load     = load;

endmodule

[rtl/io_command_completion_tracker.sv]
// Path: an event beat is queued, then fetched with its slot entry, then formed into a completion in
// the output register; a stalled output holds the update. A new event is fetched only after the
// read-modify-write of the last one through the slot table's single registered read port is done.
// Reset: control state clears at once; the slot table then runs a clearing pass over all
// SLOTS entries, one entry per cycle, during which no event is taken.
// ----------------------------------------------------------------------------
// io_command_completion_tracker: command completion scoreboard
// Per-slot outstanding flash and dma child counts with a shared fail flag;
// emits the slot and its status when a count drains to zero.
// ----------------------------------------------------------------------------
module io_command_completion_tracker import ioct_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ioct_evt_if.sink   evt_i,
  ioct_cpl_if.source cpl_o
);

  logic       q_push;
  cmd_t       q_push_cmd;
  logic       q_full;
  logic       q_pop;
  cmd_t       q_pop_cmd;
  logic       q_empty;
  back_stat_t bstat;

  // intake and classification
  ioct_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .evt_i      (evt_i),
    .clearing_i (bstat.clearing),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_push_cmd)
  );

  // decoupling queue
  ioct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_cmd_o  (q_pop_cmd),
    .empty_o    (q_empty)
  );

  // scoreboard update and completion output
  ioct_back #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cmd_i   (q_pop_cmd),
    .q_pop_o   (q_pop),
    .stat_o    (bstat),
    .cpl_o     (cpl_o)
  );

  // no event taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.clearing |-> !evt_i.ready)
    else $error("event accepted during table clear");

  // the queue is never pushed while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue overflow");

  // a new completion only loads a free or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.load |-> (!cpl_o.valid || cpl_o.ready))
    else $error("completion overwritten");

  // a completion never loads in the same cycle as a queue pop
  a_load_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.load |-> !q_pop)
    else $error("completion formed while fetching");

endmodule
